FILE: hdl/assert_macros.svh
// assertion macros used by the cipher top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/idea_pkg.sv
// shared types and constants for the idea cipher
package idea_pkg;
    localparam int KEY_ROT = 25;
    localparam int KEY_W   = 128;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
    } t_mulreq;
endpackage

FILE: hdl/idea_block_cipher.sv
// idea cipher top level: key registers, subkey memory and shared multiplier
// a new block is accepted only while the datapath is idle; one subkey read from the memory per cycle
// reset and every key write rerun the subkey schedule with input stalled; the key resets to zero
module idea_block_cipher #(
    parameter int ROUNDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [63:0] i_block_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_block_out
);
    import idea_pkg::*;
    `include "assert_macros.svh"

    localparam int NK    = 6 * ROUNDS + 4;
    localparam int DEPTH = 2 * NK;
    localparam int AW    = $clog2(DEPTH);

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    logic [63:0]   r_key_hi;
    logic [63:0]   r_key_lo;
    logic          r_restart;
    logic [15:0]   mem [DEPTH];
    logic [15:0]   r_kd;
    t_mulreq       ks_mul, dp_mul, mul_req;
    logic [15:0]   mul_res;
    logic [AW-1:0] ks_rd, dp_rd, rd_addr;
    logic          ks_we;
    logic [AW-1:0] ks_wa;
    logic [15:0]   ks_wd;
    logic          ks_busy;
    logic          dp_idle;
    logic          in_acc;

    assign o_in_stall = !dp_idle || ks_busy || r_restart || i_cfg_we;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign mul_req    = ks_busy ? ks_mul : dp_mul;
    assign rd_addr    = ks_busy ? ks_rd : dp_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi  <= '0;
            r_key_lo  <= '0;
            r_restart <= 1'b1;
        end else begin
            r_restart <= i_cfg_we;
            if (i_cfg_we && i_cfg_addr == CFG_KEY_HIGH) begin
                r_key_hi <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_addr == CFG_KEY_LOW) begin
                r_key_lo <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ks_we) begin
            mem[ks_wa] <= ks_wd;
        end
        r_kd <= mem[rd_addr];
    end

    idea_mul u_mul (
        .i_req (mul_req),
        .o_res (mul_res)
    );

    idea_ksched #(.ROUNDS(ROUNDS), .NK(NK), .AW(AW)) u_ksched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (r_restart),
        .i_key     ({r_key_hi, r_key_lo}),
        .i_kd      (r_kd),
        .i_mul_res (mul_res),
        .o_mul     (ks_mul),
        .o_rd_addr (ks_rd),
        .o_we      (ks_we),
        .o_wr_addr (ks_wa),
        .o_wr_data (ks_wd),
        .o_busy    (ks_busy)
    );

    idea_dpath #(.ROUNDS(ROUNDS), .NK(NK), .AW(AW)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_operation (i_operation),
        .i_block_in  (i_block_in),
        .i_z         (r_kd),
        .i_mul_res   (mul_res),
        .o_mul       (dp_mul),
        .o_rd_addr   (dp_rd),
        .o_idle      (dp_idle),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_block_out (o_block_out)
    );

    `ASSERT_CLK(a_acc_no_ks, i_clk, i_rst_n, in_acc |-> !ks_busy)
    `ASSERT_CLK(a_cfg_reruns, i_clk, i_rst_n, i_cfg_we |-> ##2 ks_busy)
    `ASSERT_CLK(a_mul_owner, i_clk, i_rst_n, ks_busy |-> dp_idle)
endmodule

FILE: hdl/idea_mul.sv
// multiplier modulo 65537 with a zero word standing for 65536
module idea_mul (
    input  idea_pkg::t_mulreq i_req,
    output logic [15:0]       o_res
);
    import idea_pkg::*;

    logic [31:0] prod;
    logic [15:0] lo;
    logic [15:0] hi;

    always_comb begin
        prod = 32'(i_req.a) * 32'(i_req.b);
        lo   = prod[15:0];
        hi   = prod[31:16];
        if (i_req.a == 16'd0) begin
            o_res = 16'd1 - i_req.b;
        end else if (i_req.b == 16'd0) begin
            o_res = 16'd1 - i_req.a;
        end else if (lo < hi) begin
            o_res = lo - hi + 16'd1;
        end else begin
            o_res = lo - hi;
        end
    end
endmodule

FILE: hdl/idea_ksched.sv
// subkey generator: encryption sweep then decryption inverses, negations and copies
module idea_ksched #(
    parameter int ROUNDS = 8,
    parameter int NK     = 52,
    parameter int AW     = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [idea_pkg::KEY_W-1:0]   i_key,
    input  logic [15:0]                  i_kd,
    input  logic [15:0]                  i_mul_res,
    output idea_pkg::t_mulreq            o_mul,
    output logic [AW-1:0]                o_rd_addr,
    output logic                         o_we,
    output logic [AW-1:0]                o_wr_addr,
    output logic [15:0]                  o_wr_data,
    output logic                         o_busy
);
    import idea_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);
    localparam logic [2:0] KS_LOAD = 3'd0;
    localparam logic [2:0] KS_ENC  = 3'd1;
    localparam logic [2:0] KS_RD   = 3'd2;
    localparam logic [2:0] KS_GET  = 3'd3;
    localparam logic [2:0] KS_INV  = 3'd4;
    localparam logic [2:0] KS_WR   = 3'd5;
    localparam logic [2:0] KS_DONE = 3'd6;

    logic [2:0]       r_state;
    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_n;
    logic [2:0]       r_g;
    logic [AW-1:0]    r_d;
    logic [RW-1:0]    r_rnd;
    logic [2:0]       r_p;
    logic [AW-1:0]    r_b0;
    logic [15:0]      r_x;
    logic [15:0]      r_acc;
    logic [4:0]       r_cnt;
    logic             edge_rnd;
    logic             last_d;

    assign edge_rnd = (r_rnd == '0) || (r_rnd == RW'(ROUNDS));
    assign last_d   = (r_d == AW'(NK - 1));
    assign o_busy   = (r_state != KS_DONE);

    always_comb begin
        o_mul.a = r_acc;
        o_mul.b = r_cnt[0] ? r_x : r_acc;
        case (r_p)
            3'd0:    o_rd_addr = r_b0;
            3'd1:    o_rd_addr = r_b0 + (edge_rnd ? AW'(1) : AW'(2));
            3'd2:    o_rd_addr = r_b0 + (edge_rnd ? AW'(2) : AW'(1));
            3'd3:    o_rd_addr = r_b0 + AW'(3);
            3'd4:    o_rd_addr = r_b0 - AW'(2);
            default: o_rd_addr = r_b0 - AW'(1);
        endcase
        o_we      = 1'b0;
        o_wr_addr = AW'(NK) + r_d;
        o_wr_data = r_acc;
        case (r_state)
            KS_ENC: begin
                o_we      = 1'b1;
                o_wr_addr = r_n;
                o_wr_data = r_key[(7 - r_g) * 16 +: 16];
            end
            KS_GET: begin
                o_we      = !(r_p == 3'd0 || r_p == 3'd3);
                o_wr_data = (r_p == 3'd1 || r_p == 3'd2) ? (16'd0 - i_kd) : i_kd;
            end
            KS_WR: begin
                o_we = 1'b1;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
        end else if (i_restart) begin
            r_state <= KS_LOAD;
        end else begin
            case (r_state)
                KS_LOAD: begin
                    r_key   <= i_key;
                    r_n     <= '0;
                    r_g     <= '0;
                    r_state <= KS_ENC;
                end
                KS_ENC: begin
                    r_g <= r_g + 3'd1;
                    r_n <= r_n + AW'(1);
                    if (r_g == 3'd7) begin
                        r_key <= {r_key[KEY_W-1-KEY_ROT:0], r_key[KEY_W-1:KEY_W-KEY_ROT]};
                    end
                    if (r_n == AW'(NK - 1)) begin
                        r_d     <= '0;
                        r_rnd   <= '0;
                        r_p     <= '0;
                        r_b0    <= AW'(6 * ROUNDS);
                        r_state <= KS_RD;
                    end
                end
                KS_RD: begin
                    r_state <= KS_GET;
                end
                KS_GET: begin
                    if (r_p == 3'd0 || r_p == 3'd3) begin
                        r_x     <= i_kd;
                        r_acc   <= i_kd;
                        r_cnt   <= '0;
                        r_state <= KS_INV;
                    end else if (last_d) begin
                        r_state <= KS_DONE;
                    end else begin
                        r_d     <= r_d + AW'(1);
                        r_state <= KS_RD;
                        if (r_p == 3'd5) begin
                            r_p   <= '0;
                            r_rnd <= r_rnd + RW'(1);
                            r_b0  <= r_b0 - AW'(6);
                        end else begin
                            r_p <= r_p + 3'd1;
                        end
                    end
                end
                KS_INV: begin
                    r_acc <= i_mul_res;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd29) begin
                        r_state <= KS_WR;
                    end
                end
                KS_WR: begin
                    if (last_d) begin
                        r_state <= KS_DONE;
                    end else begin
                        r_d     <= r_d + AW'(1);
                        r_p     <= r_p + 3'd1;
                        r_state <= KS_RD;
                    end
                end
                KS_DONE: begin
                    r_state <= KS_DONE;
                end
                default: begin
                    r_state <= KS_LOAD;
                end
            endcase
        end
    end
endmodule

FILE: hdl/idea_dpath.sv
// round sequencer: one subkey per cycle through the shared multiplier
module idea_dpath #(
    parameter int ROUNDS = 8,
    parameter int NK     = 52,
    parameter int AW     = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  logic [63:0]       i_block_in,
    input  logic [15:0]       i_z,
    input  logic [15:0]       i_mul_res,
    output idea_pkg::t_mulreq o_mul,
    output logic [AW-1:0]     o_rd_addr,
    output logic              o_idle,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [63:0]       o_block_out
);
    import idea_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);
    localparam logic [1:0] DP_IDLE = 2'd0;
    localparam logic [1:0] DP_RUN  = 2'd1;
    localparam logic [1:0] DP_FIN  = 2'd2;

    logic [1:0]    r_state;
    logic [15:0]   r_x1, r_x2, r_x3, r_x4, r_t1;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_pos;
    logic          r_iss;
    logic          r_pvld;
    logic [2:0]    r_phase;
    logic [RW-1:0] r_rnd;
    logic          r_ovld;
    logic [63:0]   r_oblk;
    logic [15:0]   t3;
    logic          out_rnd;
    logic          out_free;

    assign o_rd_addr   = r_base + r_pos;
    assign o_idle      = (r_state == DP_IDLE);
    assign o_out_valid = r_ovld;
    assign o_block_out = r_oblk;
    assign out_rnd     = (r_rnd == RW'(ROUNDS));
    assign out_free    = !r_ovld || !i_out_stall;
    assign t3          = r_t1 + i_mul_res;

    always_comb begin
        o_mul.b = i_z;
        case (r_phase)
            3'd0:    o_mul.a = r_x1;
            3'd3:    o_mul.a = r_x4;
            3'd4:    o_mul.a = r_x1 ^ r_x3;
            default: o_mul.a = (r_x2 ^ r_x4) + r_t1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DP_IDLE;
            r_ovld  <= 1'b0;
            r_iss   <= 1'b0;
            r_pvld  <= 1'b0;
        end else begin
            if (r_ovld && !i_out_stall && r_state != DP_FIN) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                DP_IDLE: begin
                    if (i_start) begin
                        r_x1    <= i_block_in[63:48];
                        r_x2    <= i_block_in[47:32];
                        r_x3    <= i_block_in[31:16];
                        r_x4    <= i_block_in[15:0];
                        r_base  <= i_operation ? AW'(NK) : '0;
                        r_pos   <= '0;
                        r_iss   <= 1'b1;
                        r_pvld  <= 1'b0;
                        r_phase <= '0;
                        r_rnd   <= '0;
                        r_state <= DP_RUN;
                    end
                end
                DP_RUN: begin
                    r_pvld <= r_iss;
                    if (r_iss) begin
                        if (r_pos == AW'(NK - 1)) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_pos <= r_pos + AW'(1);
                        end
                    end
                    if (r_pvld) begin
                        case (r_phase)
                            3'd0: r_x1 <= i_mul_res;
                            3'd1: begin
                                if (out_rnd) r_x3 <= r_x3 + i_z;
                                else r_x2 <= r_x2 + i_z;
                            end
                            3'd2: begin
                                if (out_rnd) r_x2 <= r_x2 + i_z;
                                else r_x3 <= r_x3 + i_z;
                            end
                            3'd3: r_x4 <= i_mul_res;
                            3'd4: r_t1 <= i_mul_res;
                            default: begin
                                r_x1 <= r_x1 ^ i_mul_res;
                                r_x2 <= r_x3 ^ i_mul_res;
                                r_x3 <= r_x2 ^ t3;
                                r_x4 <= r_x4 ^ t3;
                            end
                        endcase
                        if (r_phase == 3'd5) begin
                            r_phase <= '0;
                            r_rnd   <= r_rnd + RW'(1);
                        end else begin
                            r_phase <= r_phase + 3'd1;
                        end
                        if (out_rnd && r_phase == 3'd3) begin
                            r_state <= DP_FIN;
                        end
                    end
                end
                DP_FIN: begin
                    if (out_free) begin
                        r_oblk  <= {r_x1, r_x3, r_x2, r_x4};
                        r_ovld  <= 1'b1;
                        r_state <= DP_IDLE;
                    end
                end
                default: begin
                    r_state <= DP_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: sim/idea_block_cipher_test.sv
// testbench for the idea block cipher: predicted results against the block's output words
`timescale 1ns / 1ps

module idea_block_cipher_test;

    localparam int ROUNDS   = 8;
    localparam int NSUB     = 52;
    localparam int LATENCY  = 6 * ROUNDS + 7;
    localparam bit OP_ENC   = 1'b0;
    localparam bit OP_DEC   = 1'b1;
    localparam bit REG_KEY_HIGH = 1'b0;
    localparam bit REG_KEY_LOW  = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [63:0] i_block_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_block_out;

    logic [63:0] key_hi_q;
    logic [63:0] key_lo_q;
    logic [15:0] enc_sub [NSUB];
    logic [15:0] dec_sub [NSUB];
    logic [63:0] expected_blocks [$];
    int          errors;
    bit          stall_mode;

    idea_block_cipher #(.ROUNDS(ROUNDS)) uut (.*);

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [15:0] mul_mod(logic [15:0] a, logic [15:0] b);
        logic [33:0] x;
        logic [33:0] y;
        x = (a == 16'h0) ? 34'h10000 : {18'h0, a};
        y = (b == 16'h0) ? 34'h10000 : {18'h0, b};
        return 16'((x * y) % 34'h10001);
    endfunction

    function automatic logic [15:0] inv_mod(logic [15:0] a);
        logic [33:0] base;
        logic [33:0] acc;
        logic [16:0] e;
        base = (a == 16'h0) ? 34'h10000 : {18'h0, a};
        acc  = 34'h1;
        e    = 17'h0FFFF;
        while (e != 0) begin
            if (e[0]) acc = (acc * base) % 34'h10001;
            base = (base * base) % 34'h10001;
            e = e >> 1;
        end
        return acc[15:0];
    endfunction

    function automatic void build_schedule();
        logic [127:0] k;
        int           b;
        int           d;
        k = {key_hi_q, key_lo_q};
        for (int n = 0; n < NSUB; n++) begin
            if (n > 0 && n % 8 == 0) k = {k[102:0], k[127:103]};
            enc_sub[n] = k[127 - 16 * (n % 8) -: 16];
        end
        for (int n = 0; n < NSUB; n++) dec_sub[n] = 16'h0;
        for (int r = 0; r <= ROUNDS; r++) begin
            b = 6 * (ROUNDS - r);
            d = 6 * r;
            dec_sub[d] = inv_mod(enc_sub[b]);
            if (r == 0 || r == ROUNDS) begin
                dec_sub[d + 1] = -enc_sub[b + 1];
                dec_sub[d + 2] = -enc_sub[b + 2];
            end else begin
                dec_sub[d + 1] = -enc_sub[b + 2];
                dec_sub[d + 2] = -enc_sub[b + 1];
            end
            dec_sub[d + 3] = inv_mod(enc_sub[b + 3]);
            if (r < ROUNDS) begin
                dec_sub[d + 4] = enc_sub[b - 2];
                dec_sub[d + 5] = enc_sub[b - 1];
            end
        end
    endfunction

    function automatic logic [63:0] cipher_block(bit op, logic [63:0] blk);
        logic [15:0] z [NSUB];
        logic [15:0] x1, x2, x3, x4, a, b, c, d, t1, t2, t3;
        for (int n = 0; n < NSUB; n++) z[n] = (op == OP_DEC) ? dec_sub[n] : enc_sub[n];
        {x1, x2, x3, x4} = blk;
        for (int r = 0; r < ROUNDS; r++) begin
            a  = mul_mod(x1, z[6 * r]);
            b  = x2 + z[6 * r + 1];
            c  = x3 + z[6 * r + 2];
            d  = mul_mod(x4, z[6 * r + 3]);
            t1 = mul_mod(a ^ c, z[6 * r + 4]);
            t2 = mul_mod((b ^ d) + t1, z[6 * r + 5]);
            t3 = t1 + t2;
            x1 = a ^ t2;
            x2 = c ^ t2;
            x3 = b ^ t3;
            x4 = d ^ t3;
        end
        return {mul_mod(x1, z[6 * ROUNDS]), 16'(x3 + z[6 * ROUNDS + 1]),
                16'(x2 + z[6 * ROUNDS + 2]), mul_mod(x4, z[6 * ROUNDS + 3])};
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_mode) begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t unexpected word: expected none, actual %h", $time, o_block_out);
                errors++;
            end else begin
                if (o_block_out !== expected_blocks[0]) begin
                    $display("%0t block_out mismatch: expected %h, actual %h",
                             $time, expected_blocks[0], o_block_out);
                    errors++;
                end
                void'(expected_blocks.pop_front());
            end
        end
    end

    task automatic send_block(bit op, logic [63:0] blk);
        @(posedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_block_in  <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_blocks.push_back(cipher_block(op, blk));
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_key(bit idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_q = value;
        else key_lo_q = value;
        build_schedule();
    endtask

    task automatic test_zero_key();
        send_block(OP_ENC, 64'h0);
        send_block(OP_DEC, 64'h0);
        send_block(OP_ENC, '1);
        send_block(OP_DEC, '1);
        drain();
    endtask

    task automatic test_directed_keys();
        write_key(REG_KEY_HIGH, 64'h0001_0002_0003_0004);
        write_key(REG_KEY_LOW, 64'h0005_0006_0007_0008);
        send_block(OP_ENC, 64'h0000_0001_0002_0003);
        send_block(OP_DEC, 64'h11FB_ED2B_0198_6DE5);
        send_block(OP_ENC, 64'h0000_FFFF_0000_FFFF);
        send_block(OP_DEC, 64'hFFFF_0000_FFFF_0000);
        send_block(OP_ENC, 64'h8000_0000_0000_0001);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block(OP_ENC, 64'h0);
        send_block(OP_DEC, 64'h0);
        send_block(OP_ENC, '1);
        send_block(OP_DEC, 64'h5555_AAAA_5555_AAAA);
        drain();
        write_key(REG_KEY_HIGH, 64'h0);
        send_block(OP_ENC, 64'h0123_4567_89AB_CDEF);
        send_block(OP_DEC, 64'h0123_4567_89AB_CDEF);
        drain();
    endtask

    task automatic test_random_blocks(int count);
        logic [63:0] blk;
        int          burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                repeat ($urandom_range(0, 20)) @(posedge i_clk);
                burst = $urandom_range(1, 12);
            end
            burst--;
            blk = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0: blk[63:48] = 16'h0;
                1: blk[15:0] = 16'h0;
                2: blk = {$urandom_range(0, 1) ? 16'h0 : 16'hFFFF, blk[47:0]};
                default: ;
            endcase
            send_block(bit'($urandom_range(0, 1)), blk);
        end
        drain();
    endtask

    task automatic test_random_keys();
        for (int p = 0; p < 4; p++) begin
            write_key(REG_KEY_HIGH, {$urandom, $urandom});
            write_key(REG_KEY_LOW, {$urandom, $urandom});
            stall_mode = (p % 2 == 0);
            test_random_blocks(96);
        end
    endtask

    initial begin
        errors      = 0;
        stall_mode  = 1'b0;
        key_hi_q    = 64'h0;
        key_lo_q    = 64'h0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_KEY_HIGH;
        i_cfg_data  = 64'h0;
        i_in_valid  = 1'b0;
        i_operation = OP_ENC;
        i_block_in  = 64'h0;
        build_schedule();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_key();
        stall_mode = 1'b1;
        test_directed_keys();
        test_random_keys();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/idea_pkg.sv
hdl/idea_mul.sv
hdl/idea_ksched.sv
hdl/idea_dpath.sv
hdl/idea_block_cipher.sv
sim/idea_block_cipher_test.sv
